### design/spgc_pkg.sv
// Shared types, constants and register codes of the scan point gap clusterer.
`timescale 1ns / 1ps

package spgc_pkg;

  localparam int unsigned MAX_POINTS_DEF = 32;
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned RANGE_W        = 16;
  localparam int unsigned GAP_W          = 16;
  localparam int unsigned MINSZ_W        = 6;
  localparam int unsigned CLNUM_W        = 8;
  localparam int unsigned PADDR_W        = 4;
  localparam int unsigned PDATA_W        = 32;
  localparam int unsigned PROD_W         = 2 * GAP_W;

  localparam logic [GAP_W-1:0]   GAP_RST   = GAP_W'(300);
  localparam logic [RANGE_W-1:0] RANGE_RST = RANGE_W'(2000);
  localparam logic [MINSZ_W-1:0] MINSZ_RST = MINSZ_W'(1);

  typedef enum logic [1:0] {
    REG_GAP   = 2'd0,
    REG_RANGE = 2'd1,
    REG_MINSZ = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    SQ_HOLD = 2'd0,
    SQ_DX   = 2'd1,
    SQ_DY   = 2'd2,
    SQ_G    = 2'd3
  } sq_op_e;

  typedef struct packed {
    logic [GAP_W-1:0]   gap_threshold;
    logic [RANGE_W-1:0] range_limit;
    logic [MINSZ_W-1:0] min_cluster_size;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [RANGE_W-1:0]        point_range;
    logic                      scan_end;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic [CLNUM_W-1:0]        cluster_number;
    logic                      cluster_end;
    logic                      run_end;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_word_t;

endpackage

### design/spgc_stream_if.sv
// Valid/ready stream channel carrying one word of a given payload type.
`timescale 1ns / 1ps

interface spgc_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

### design/spgc_regs.sv
// APB-style configuration registers of the clusterer.
`timescale 1ns / 1ps

module spgc_regs import spgc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_GAP:   cfg_d.gap_threshold    = pwdata[GAP_W-1:0];
        REG_RANGE: cfg_d.range_limit      = pwdata[RANGE_W-1:0];
        REG_MINSZ: cfg_d.min_cluster_size = pwdata[MINSZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAP:   prdata = PDATA_W'(cfg_q.gap_threshold);
      REG_RANGE: prdata = PDATA_W'(cfg_q.range_limit);
      REG_MINSZ: prdata = PDATA_W'(cfg_q.min_cluster_size);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_threshold    <= GAP_RST;
      cfg_q.range_limit      <= RANGE_RST;
      cfg_q.min_cluster_size <= MINSZ_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### design/spgc_sq_unit.sv
// Shared squaring multiplier with accumulator and gap compare.
`timescale 1ns / 1ps

module spgc_sq_unit import spgc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sq_op_e           op_i,
  input  logic [GAP_W-1:0] dx_i,
  input  logic [GAP_W-1:0] dy_i,
  input  logic [GAP_W-1:0] gap_i,
  output logic             gap_o
);

  logic [GAP_W-1:0]  op_a;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W:0]   acc_q;

  always_comb begin
    case (op_i)
      SQ_DX:   op_a = dx_i;
      SQ_DY:   op_a = dy_i;
      SQ_G:    op_a = gap_i;
      default: op_a = '0;
    endcase
  end

  assign gap_o = acc_q > {1'b0, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      if (op_i != SQ_HOLD) begin
        prod_q <= PROD_W'(op_a) * PROD_W'(op_a);
      end
      if (op_i == SQ_DY) begin
        acc_q <= {1'b0, prod_q};
      end else if (op_i == SQ_G) begin
        acc_q <= acc_q + {1'b0, prod_q};
      end
    end
  end

endmodule

### design/spgc_store.sv
// Cluster point store: one write port, one registered read port.
`timescale 1ns / 1ps

module spgc_store import spgc_pkg::*; #(
  parameter int unsigned DEPTH = MAX_POINTS_DEF,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  point_word_t       wdata_i,
  input  logic [IDX_W-1:0]  raddr_i,
  output point_word_t       rdata_o
);

  point_word_t mem_q [DEPTH];
  point_word_t rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

endmodule

### design/scan_point_gap_clusterer_unit.sv
// Top level: lidar scan point gap clusterer with sequencer and output register.
// Sequence: an accepted point goes from idle through decide, add and flush; with a gap test it
// first makes three passes through the shared squaring multiplier (dx, dy, gap). Each emitted word
// takes a store read, then an output register load, and is held longer while the output stalls.
// A new point is taken only in the idle state, once the last point and all its words are done.
// Reset: registers return to defaults, cluster state empties; the store is not cleared.
`timescale 1ns / 1ps

module scan_point_gap_clusterer_unit import spgc_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  spgc_stream_if.sink        pt_i,
  spgc_stream_if.source      res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned CMP_W = MINSZ_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DX,
    ST_MUL_DY,
    ST_MUL_G,
    ST_DECIDE,
    ST_ADD,
    ST_FLUSH,
    ST_RD,
    ST_PUT
  } state_e;

  state_e                    state_q, state_d;
  logic signed [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [COORD_W-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic                      prev_valid_q, prev_valid_d;
  logic                      in_range_q, in_range_d;
  logic                      last_q, last_d;
  logic                      gap_test_q, gap_test_d;
  logic [GAP_W-1:0]          dx_q, dx_d, dy_q, dy_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CLNUM_W-1:0]        emitted_q, emitted_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic                      phase_q, phase_d;
  logic                      final_q, final_d;
  logic                      out_valid_q, out_valid_d;
  result_t                   out_q, out_d;

  cfg_t        cfg;
  sq_op_e      sq_op;
  logic        sq_gap;
  logic        we;
  point_word_t rdata;
  point_t      pt;
  logic        pt_fire;
  logic        res_fire;
  logic        out_load;
  logic        emit_ok;
  logic        min_le1;
  logic        is_last;
  logic        in_range;
  logic [COORD_W:0] diff_x, diff_y;

  spgc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spgc_sq_unit u_sq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (sq_op),
    .dx_i   (dx_q),
    .dy_i   (dy_q),
    .gap_i  (cfg.gap_threshold),
    .gap_o  (sq_gap)
  );

  spgc_store #(
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i ({x_q, y_q}),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign pt          = pt_i.payload;
  assign pt_i.ready  = (state_q == ST_IDLE);
  assign pt_fire     = pt_i.valid && pt_i.ready;
  assign res_o.valid = out_valid_q;
  assign res_o.payload = out_q;
  assign res_fire    = res_o.valid && res_o.ready;

  assign in_range = pt.point_range <= cfg.range_limit;
  assign diff_x   = {pt.point_x[COORD_W-1], pt.point_x} - {prev_x_q[COORD_W-1], prev_x_q};
  assign diff_y   = {pt.point_y[COORD_W-1], pt.point_y} - {prev_y_q[COORD_W-1], prev_y_q};
  assign emit_ok  = (count_q != '0) && (CMP_W'(count_q) >= CMP_W'(cfg.min_cluster_size));
  assign min_le1  = cfg.min_cluster_size <= MINSZ_W'(1);
  assign is_last  = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    y_d          = y_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    prev_valid_d = prev_valid_q;
    in_range_d   = in_range_q;
    last_d       = last_q;
    gap_test_d   = gap_test_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    count_d      = count_q;
    emitted_d    = emitted_q;
    idx_d        = idx_q;
    phase_d      = phase_q;
    final_d      = final_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    sq_op        = SQ_HOLD;
    we           = 1'b0;
    out_load     = 1'b0;

    if (res_fire) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (pt_fire) begin
          x_d          = pt.point_x;
          y_d          = pt.point_y;
          in_range_d   = in_range;
          last_d       = pt.scan_end;
          gap_test_d   = in_range && !pt.scan_end && prev_valid_q;
          dx_d         = diff_x[COORD_W] ? GAP_W'(-diff_x) : GAP_W'(diff_x);
          dy_d         = diff_y[COORD_W] ? GAP_W'(-diff_y) : GAP_W'(diff_y);
          prev_x_d     = pt.point_x;
          prev_y_d     = pt.point_y;
          prev_valid_d = !pt.scan_end;
          state_d      = (in_range && !pt.scan_end && prev_valid_q) ? ST_MUL_DX : ST_DECIDE;
        end
      end
      ST_MUL_DX: begin
        sq_op   = SQ_DX;
        state_d = ST_MUL_DY;
      end
      ST_MUL_DY: begin
        sq_op   = SQ_DY;
        state_d = ST_MUL_G;
      end
      ST_MUL_G: begin
        sq_op   = SQ_G;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = ST_ADD;
        if (in_range_q && ((gap_test_q && sq_gap) || count_q == CNT_W'(MAX_POINTS))) begin
          phase_d = 1'b0;
          final_d = !(last_q && min_le1);
          if (emit_ok) begin
            idx_d   = '0;
            state_d = ST_RD;
          end else begin
            count_d = '0;
          end
        end
      end
      ST_ADD: begin
        if (in_range_q) begin
          we      = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
        state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_d = ST_IDLE;
        if (last_q) begin
          phase_d = 1'b1;
          final_d = 1'b1;
          if (emit_ok) begin
            idx_d   = '0;
            state_d = ST_RD;
          end else begin
            count_d   = '0;
            emitted_d = '0;
          end
        end
      end
      ST_RD: begin
        state_d = ST_PUT;
      end
      ST_PUT: begin
        if (!out_valid_q || res_o.ready) begin
          out_load             = 1'b1;
          out_valid_d          = 1'b1;
          out_d.out_x          = rdata.x;
          out_d.out_y          = rdata.y;
          out_d.cluster_number = emitted_q;
          out_d.cluster_end    = is_last;
          out_d.run_end        = is_last && final_q;
          if (is_last) begin
            count_d   = '0;
            emitted_d = phase_q ? '0 : emitted_q + CLNUM_W'(1);
            state_d   = phase_q ? ST_IDLE : ST_ADD;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      x_q          <= '0;
      y_q          <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_valid_q <= 1'b0;
      in_range_q   <= 1'b0;
      last_q       <= 1'b0;
      gap_test_q   <= 1'b0;
      dx_q         <= '0;
      dy_q         <= '0;
      count_q      <= '0;
      emitted_q    <= '0;
      idx_q        <= '0;
      phase_q      <= 1'b0;
      final_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      x_q          <= x_d;
      y_q          <= y_d;
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      prev_valid_q <= prev_valid_d;
      in_range_q   <= in_range_d;
      last_q       <= last_d;
      gap_test_q   <= gap_test_d;
      dx_q         <= dx_d;
      dy_q         <= dy_d;
      count_q      <= count_d;
      emitted_q    <= emitted_d;
      idx_q        <= idx_d;
      phase_q      <= phase_d;
      final_q      <= final_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_fire |=> !pt_i.ready)
    else $error("point taken while previous point still in work");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("cluster count exceeds buffer depth");

  a_read_in_cluster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PUT |-> CNT_W'(idx_q) < count_q)
    else $error("store read beyond open cluster");

  a_more_words_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !out_d.run_end |=> !pt_i.ready)
    else $error("ready raised before the last word of a point");

  a_write_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> count_q < CNT_W'(MAX_POINTS))
    else $error("store write into full cluster");

endmodule

### tb/tb.sv
// Self-checking testbench of the scan point gap clusterer: table-driven and random scans.
`timescale 1ns / 1ps

module tb;
  import spgc_pkg::*;

  localparam int IDLE_PCT      = 38;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int REPORT_LIMIT  = 10;
  localparam int PREDICT       = -1;
  localparam int NUM_DIRECTED  = 17;
  localparam int NUM_PHASES    = 5;
  localparam int SCAN_ITEMS    = 43;
  localparam int EXTREMES [4]  = '{-32768, 32767, 0, -1};

  typedef struct {
    int      typed_n;
    result_t typed;
  } note_t;

  typedef struct {
    point_t pt;
    note_t  note;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  spgc_stream_if #(.payload_t(point_t))  pt_if ();
  spgc_stream_if #(.payload_t(result_t)) res_if ();

  scan_point_gap_clusterer_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pt_i    (pt_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  row_t directed_rows [NUM_DIRECTED] = '{
    '{'{16'sd100, 16'sd200, 16'd0, 1'b1}, '{1, '{16'sd100, 16'sd200, 8'd0, 1'b1, 1'b1}}},
    '{'{16'sd0, 16'sd0, 16'd65535, 1'b0}, '{0, '0}},
    '{'{16'sd0, 16'sd0, 16'd2000, 1'b1}, '{1, '{16'sd0, 16'sd0, 8'd0, 1'b1, 1'b1}}},
    '{'{16'sd0, 16'sd0, 16'd2001, 1'b1}, '{0, '0}},
    '{'{16'sh7FFF, 16'sh7FFF, 16'd0, 1'b0}, '{0, '0}},
    '{'{16'sh8000, 16'sh8000, 16'd0, 1'b0}, '{PREDICT, '0}},
    '{'{16'sh8000, 16'sh8000, 16'd1, 1'b0}, '{PREDICT, '0}},
    '{'{-16'sd32500, 16'sh8000, 16'd0, 1'b0}, '{PREDICT, '0}},
    '{'{-16'sd32200, 16'sh8000, 16'd0, 1'b0}, '{PREDICT, '0}},
    '{'{-16'sd31899, 16'sh8000, 16'd0, 1'b0}, '{PREDICT, '0}},
    '{'{16'sd30000, -16'sd30000, 16'd2000, 1'b1}, '{PREDICT, '0}},
    '{'{16'shFFFF, 16'shFFFF, 16'd0, 1'b0}, '{PREDICT, '0}},
    '{'{16'shFFFF, 16'sd299, 16'd65535, 1'b0}, '{PREDICT, '0}},
    '{'{16'shFFFF, -16'sd2, 16'd0, 1'b0}, '{PREDICT, '0}},
    '{'{16'sd180, 16'sd238, 16'd0, 1'b0}, '{PREDICT, '0}},
    '{'{16'sd360, 16'sd478, 16'd0, 1'b0}, '{PREDICT, '0}},
    '{'{16'sd0, 16'sd0, 16'd65535, 1'b1}, '{PREDICT, '0}}
  };

  cfg_t phase_cfgs [NUM_PHASES] = '{
    '{16'd0, 16'd65535, 6'd0},
    '{16'd65535, 16'd0, 6'd32},
    '{16'd50, 16'd1000, 6'd3},
    '{16'd1000, 16'd40000, 6'd63},
    '{16'd200, 16'd30000, 6'd2}
  };

  cfg_t                      shadow_cfg;
  logic signed [COORD_W-1:0] last_x;
  logic signed [COORD_W-1:0] last_y;
  logic                      last_seen;
  point_word_t               held_points [MAX_POINTS_DEF];
  int                        held;
  logic [CLNUM_W-1:0]        cluster_idx;

  result_t step_words [$];
  result_t expected_words [$];
  note_t   typed_notes [$];
  int      mismatch_count;
  int      stall_cycles;
  bit      no_gaps;
  bit      hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("MISMATCH %0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void close_cluster();
    result_t w;
    if (held > 0 && held >= int'(shadow_cfg.min_cluster_size)) begin
      for (int k = 0; k < held; k++) begin
        w.out_x          = held_points[k].x;
        w.out_y          = held_points[k].y;
        w.cluster_number = cluster_idx;
        w.cluster_end    = (k == held - 1);
        w.run_end        = 1'b0;
        step_words.insert(step_words.size(), w);
      end
      cluster_idx++;
    end
    held = 0;
  endfunction

  function automatic void cluster_predict(point_t p);
    longint dx;
    longint dy;
    longint g;
    step_words.delete();
    if (p.point_range <= shadow_cfg.range_limit) begin
      if (!p.scan_end && last_seen) begin
        dx = longint'(p.point_x) - longint'(last_x);
        dy = longint'(p.point_y) - longint'(last_y);
        g  = longint'(shadow_cfg.gap_threshold);
        if (dx * dx + dy * dy > g * g) begin
          close_cluster();
        end
      end
      if (held >= MAX_POINTS_DEF) begin
        close_cluster();
      end
      held_points[held].x = p.point_x;
      held_points[held].y = p.point_y;
      held++;
    end
    last_x    = p.point_x;
    last_y    = p.point_y;
    last_seen = 1'b1;
    if (p.scan_end) begin
      close_cluster();
      last_seen   = 1'b0;
      cluster_idx = '0;
    end
    if (step_words.size() > 0) begin
      step_words[step_words.size() - 1].run_end = 1'b1;
    end
  endfunction

  function automatic logic [PDATA_W-1:0] reg_value(reg_idx_e idx);
    case (idx)
      REG_GAP:   return PDATA_W'(shadow_cfg.gap_threshold);
      REG_RANGE: return PDATA_W'(shadow_cfg.range_limit);
      REG_MINSZ: return PDATA_W'(shadow_cfg.min_cluster_size);
      default:   return '0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    note_t   nt;
    result_t exp_w;
    result_t got;
    if (rst_ni) begin
      if (pt_if.valid && pt_if.ready) begin
        nt = typed_notes.pop_front();
        cluster_predict(pt_if.payload);
        if (nt.typed_n == PREDICT) begin
          foreach (step_words[i]) expected_words.insert(expected_words.size(), step_words[i]);
        end else if (nt.typed_n == 1) begin
          expected_words.insert(expected_words.size(), nt.typed);
        end
      end
      if (res_if.valid && res_if.ready) begin
        got = res_if.payload;
        if (expected_words.size() == 0) begin
          note_mismatch($sformatf("unexpected word x=%0d y=%0d cl=%0d ce=%0b re=%0b",
                                  got.out_x, got.out_y, got.cluster_number,
                                  got.cluster_end, got.run_end));
        end else begin
          exp_w = expected_words.pop_front();
          if (got.out_x !== exp_w.out_x || got.out_y !== exp_w.out_y ||
              got.cluster_number !== exp_w.cluster_number ||
              got.cluster_end !== exp_w.cluster_end || got.run_end !== exp_w.run_end) begin
            note_mismatch($sformatf(
              "expected x=%0d y=%0d cl=%0d ce=%0b re=%0b, got x=%0d y=%0d cl=%0d ce=%0b re=%0b",
              exp_w.out_x, exp_w.out_y, exp_w.cluster_number, exp_w.cluster_end,
              exp_w.run_end, got.out_x, got.out_y, got.cluster_number, got.cluster_end,
              got.run_end));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles = 0;
    end else if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready) ||
                 (psel && penable && pready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("scan_point_gap_clusterer_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req     = 1'b0;
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      res_if.ready = no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic send_point(point_t p, note_t nt);
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      pt_if.valid = 1'b0;
      @(negedge clk_i);
    end
    typed_notes.insert(typed_notes.size(), nt);
    pt_if.valid   = 1'b1;
    pt_if.payload = p;
    do @(posedge clk_i); while (!pt_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_scans(int goal, bit full_first);
    int     sent;
    int     len;
    int     span;
    int     gx;
    int     gy;
    bit     first;
    point_t p;
    sent  = 0;
    first = full_first;
    gx    = 0;
    gy    = 0;
    span  = int'(shadow_cfg.gap_threshold) + int'(shadow_cfg.gap_threshold) / 4 + 2;
    if (span > 20000) span = 20000;
    while (sent < goal) begin
      if (first) len = MAX_POINTS_DEF + 1;
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(33, 40);
      else len = $urandom_range(1, 12);
      if (len > goal - sent) len = goal - sent;
      for (int k = 0; k < len; k++) begin
        if (first) begin
          if (k == 0) begin
            p.point_x = COORD_W'($urandom);
            p.point_y = COORD_W'($urandom);
          end
          p.point_range = '0;
        end else begin
          case ($urandom_range(0, 9))
            0: begin
              gx = int'($urandom_range(0, 65535)) - 32768;
              gy = int'($urandom_range(0, 65535)) - 32768;
            end
            1: begin
              gx = EXTREMES[$urandom_range(0, 3)];
              gy = EXTREMES[$urandom_range(0, 3)];
            end
            default: begin
              gx = gx + int'($urandom_range(0, 2 * span)) - span;
              gy = gy + int'($urandom_range(0, 2 * span)) - span;
            end
          endcase
          p.point_x = COORD_W'(gx);
          p.point_y = COORD_W'(gy);
          gx        = int'(p.point_x);
          gy        = int'(p.point_y);
          case ($urandom_range(0, 9))
            0:       p.point_range = shadow_cfg.range_limit;
            1:       p.point_range = shadow_cfg.range_limit + 16'd1;
            2:       p.point_range = RANGE_W'($urandom_range(0, 65535));
            default: p.point_range = RANGE_W'($urandom_range(0, int'(shadow_cfg.range_limit)));
          endcase
        end
        p.scan_end = (k == len - 1) || (!first && $urandom_range(0, 29) == 0);
        send_point(p, '{PREDICT, '0});
        sent++;
      end
      first = 1'b0;
    end
  endtask

  task automatic apb_access(bit wr, reg_idx_e idx, logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = PADDR_W'({idx, 2'b00});
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_regs();
    logic [PDATA_W-1:0] rd;
    for (int r = int'(REG_GAP); r <= int'(REG_MINSZ); r++) begin
      apb_access(1'b0, reg_idx_e'(r), '0, rd);
      if (rd !== reg_value(reg_idx_e'(r))) begin
        note_mismatch($sformatf("register %s: expected %0d, got %0d",
                                reg_idx_e'(r), reg_value(reg_idx_e'(r)), rd));
      end
    end
  endtask

  task automatic wait_idle();
    pt_if.valid = 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    logic [PDATA_W-1:0] rd;
    rst_ni         = 1'b0;
    pt_if.valid    = 1'b0;
    pt_if.payload  = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    no_gaps        = 1'b0;
    hold_req       = 1'b0;
    mismatch_count = 0;
    shadow_cfg     = '{GAP_RST, RANGE_RST, MINSZ_RST};
    last_x         = '0;
    last_y         = '0;
    last_seen      = 1'b0;
    held           = 0;
    cluster_idx    = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    check_regs();

    foreach (directed_rows[i]) send_point(directed_rows[i].pt, directed_rows[i].note);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      shadow_cfg = phase_cfgs[ph];
      for (int r = int'(REG_GAP); r <= int'(REG_MINSZ); r++) begin
        apb_access(1'b1, reg_idx_e'(r), reg_value(reg_idx_e'(r)), rd);
      end
      check_regs();
      no_gaps = (ph == 2);
      if (ph == 0) hold_req = 1'b1;
      send_scans(SCAN_ITEMS, ph == 0 || ph == 4);
    end

    wait_idle();
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("scan_point_gap_clusterer_unit test passed");
    end else begin
      $display("scan_point_gap_clusterer_unit test failed");
    end
    $finish;
  end

endmodule
